// ----- rtl/ppc_pkg.sv -----
// Shared types, constants and character class functions for the passcode policy checker.
package ppc_pkg;

	localparam int DEF_MAX_PASSCODE = 256;
	localparam int DEF_CODE_SPACE = 256;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 9;
	localparam int LEN_W = 9;
	localparam int MASK_W = 9;

	localparam logic [LEN_W-1:0] MAX_LENGTH_RST = 9'd256;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_LENGTH = 3'd0,
		REG_MAX_LENGTH = 3'd1,
		REG_MAX_REPEAT = 3'd2,
		REG_NEED_LETTERS_DIGITS = 3'd3,
		REG_NEED_UPPER_LOWER = 3'd4,
		REG_FORBID_ADJ_DIGITS = 3'd5,
		REG_MIN_NONLETTERS = 3'd6,
		REG_FORBID_SIMPLE = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [LEN_W-1:0] min_length;
		logic [LEN_W-1:0] max_length;
		logic [LEN_W-1:0] max_repeat;
		logic need_letters_digits;
		logic need_upper_lower;
		logic forbid_adjacent_digits;
		logic [LEN_W-1:0] min_nonletters;
		logic forbid_simple;
	} cfg_t;

	typedef enum logic [1:0] {
		ST_ACCEPT = 2'd0,
		ST_ARG_ERR = 2'd1,
		ST_VIOLATION = 2'd2
	} status_t;

	typedef struct packed {
		logic upper;
		logic lower;
		logic space;
		logic repeat_hit;
		logic adj_digit;
		logic all_same;
		logic ascending;
	} flags_t;

	localparam flags_t FLAGS_CLEAR = '{
		upper: 1'b0, lower: 1'b0, space: 1'b0, repeat_hit: 1'b0,
		adj_digit: 1'b0, all_same: 1'b1, ascending: 1'b1
	};

	localparam int MB_SHORT = 0;
	localparam int MB_LONG = 1;
	localparam int MB_REPEAT = 2;
	localparam int MB_LETTERS_DIGITS = 3;
	localparam int MB_ADJ_DIGITS = 4;
	localparam int MB_CASE = 5;
	localparam int MB_NONLETTERS = 6;
	localparam int MB_ALL_SAME = 7;
	localparam int MB_ASCENDING = 8;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_upper(input logic [7:0] c);
		return (c >= 8'h41) && (c <= 8'h5a);
	endfunction

	function automatic logic is_lower(input logic [7:0] c);
		return (c >= 8'h61) && (c <= 8'h7a);
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return is_upper(c) || is_lower(c);
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return is_letter(c) || is_digit(c);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
	endfunction

endpackage

// ----- rtl/ppc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module ppc_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/ppc_cfg_regs.sv -----
// Policy configuration registers with write port.
module ppc_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ppc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ppc_pkg::CFG_DATA_W-1:0]    cfg_data,
	output ppc_pkg::cfg_t                     cfg
);

	ppc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{
				min_length: '0, max_length: ppc_pkg::MAX_LENGTH_RST, max_repeat: '0,
				need_letters_digits: 1'b0, need_upper_lower: 1'b0,
				forbid_adjacent_digits: 1'b0, min_nonletters: '0, forbid_simple: 1'b0
			};
		end else if (cfg_we) begin
			case (ppc_pkg::cfg_reg_t'(cfg_index))
				ppc_pkg::REG_MIN_LENGTH: cfg_q.min_length <= cfg_data;
				ppc_pkg::REG_MAX_LENGTH: cfg_q.max_length <= cfg_data;
				ppc_pkg::REG_MAX_REPEAT: cfg_q.max_repeat <= cfg_data;
				ppc_pkg::REG_NEED_LETTERS_DIGITS: cfg_q.need_letters_digits <= cfg_data[0];
				ppc_pkg::REG_NEED_UPPER_LOWER: cfg_q.need_upper_lower <= cfg_data[0];
				ppc_pkg::REG_FORBID_ADJ_DIGITS: cfg_q.forbid_adjacent_digits <= cfg_data[0];
				ppc_pkg::REG_MIN_NONLETTERS: cfg_q.min_nonletters <= cfg_data;
				ppc_pkg::REG_FORBID_SIMPLE: cfg_q.forbid_simple <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/ppc_policy_eval.sv -----
// End-of-passcode policy evaluation: status and failed-policy mask.
module ppc_policy_eval #(
	parameter int CNT_W = 9
) (
	input  ppc_pkg::cfg_t                 cfg,
	input  logic [CNT_W-1:0]              len_cnt,
	input  logic [CNT_W-1:0]              dig_cnt,
	input  logic [CNT_W-1:0]              ltr_cnt,
	input  logic [CNT_W-1:0]              nonltr_cnt,
	input  ppc_pkg::flags_t               flags,
	output ppc_pkg::status_t              status,
	output logic [ppc_pkg::MASK_W-1:0]    mask
);

	localparam int CMP_W = (CNT_W > ppc_pkg::LEN_W) ? CNT_W : ppc_pkg::LEN_W;

	logic [CMP_W-1:0] len_w, dig_w, ltr_w, nonltr_w;
	logic [CMP_W-1:0] min_len_w, max_len_w, min_nonltr_w;

	always_comb begin
		len_w = CMP_W'(len_cnt);
		dig_w = CMP_W'(dig_cnt);
		ltr_w = CMP_W'(ltr_cnt);
		nonltr_w = CMP_W'(nonltr_cnt);
		min_len_w = CMP_W'(cfg.min_length);
		max_len_w = CMP_W'(cfg.max_length);
		min_nonltr_w = CMP_W'(cfg.min_nonletters);

		mask = '0;
		if (cfg.min_length != '0) begin
			if (len_w < min_len_w) begin
				mask[ppc_pkg::MB_SHORT] = 1'b1;
			end else if (len_w > max_len_w) begin
				mask[ppc_pkg::MB_LONG] = 1'b1;
			end
		end
		mask[ppc_pkg::MB_REPEAT] = (cfg.max_repeat != '0) && flags.repeat_hit;
		mask[ppc_pkg::MB_LETTERS_DIGITS] = cfg.need_letters_digits &&
			((dig_w >= len_w) || (ltr_w >= len_w) || (dig_w == '0) || (ltr_w == '0));
		mask[ppc_pkg::MB_ADJ_DIGITS] = cfg.forbid_adjacent_digits && flags.adj_digit;
		mask[ppc_pkg::MB_CASE] = cfg.need_upper_lower && !(flags.upper && flags.lower);
		mask[ppc_pkg::MB_NONLETTERS] = (cfg.min_nonletters != '0) && (nonltr_w < min_nonltr_w);
		mask[ppc_pkg::MB_ALL_SAME] = cfg.forbid_simple && flags.all_same;
		mask[ppc_pkg::MB_ASCENDING] = cfg.forbid_simple && flags.ascending;

		if (flags.space) begin
			mask = '0;
			status = ppc_pkg::ST_ARG_ERR;
		end else if (mask != '0) begin
			status = ppc_pkg::ST_VIOLATION;
		end else begin
			status = ppc_pkg::ST_ACCEPT;
		end
	end

endmodule

// ----- rtl/passcode_policy_checker_top.sv -----
// Passcode policy checker top level: count store pipeline, tallies and result register.
// A result is shown on out_valid from the output register after the ending word leaves stage 1.
// Throughput: one word per cycle; set by the per-code count read-modify-write with forwarding.
// A new word is taken while a finished result waits; only an ending word stalls on a full output.
// Reset (arst_n low) loads the register defaults and clears all passcode state and count
// valid bits at once; no clearing pass runs, words are accepted as soon as reset is released.
module passcode_policy_checker_top #(
	parameter int MAX_PASSCODE = ppc_pkg::DEF_MAX_PASSCODE,
	parameter int CODE_SPACE = ppc_pkg::DEF_CODE_SPACE
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ppc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ppc_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        char_code,
	input  logic                              is_last,
	input  logic                              is_empty,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        status,
	output logic [ppc_pkg::MASK_W-1:0]        failed_mask
);

	localparam int SAT = MAX_PASSCODE + 1;
	localparam int CNT_W = $clog2(SAT + 1);
	localparam int CMP_W = (CNT_W > ppc_pkg::LEN_W) ? CNT_W : ppc_pkg::LEN_W;
	localparam int CODE_DEPTH = (CODE_SPACE < 256) ? CODE_SPACE : 256;
	localparam int ADDR_W = $clog2(CODE_DEPTH);

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v < CNT_W'(SAT)) ? v + CNT_W'(1) : v;
	endfunction

	ppc_pkg::cfg_t cfg;

	ppc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// input side
	logic accept;
	logic [31:0] code_w;
	logic [ADDR_W-1:0] in_idx;

	always_comb begin
		code_w = {24'd0, char_code};
		if (code_w >= 32'(CODE_SPACE)) begin
			code_w = code_w - 32'(CODE_SPACE);
		end
		in_idx = code_w[ADDR_W-1:0];
	end

	assign accept = in_valid && in_ready;

	// stage 1
	logic valid_s1;
	logic [7:0] char_s1;
	logic last_s1, empty_s1;
	logic [ADDR_W-1:0] idx_s1;
	logic fwd_s1;
	logic [CNT_W-1:0] fwd_data_s1;

	// passcode state
	logic [CNT_W-1:0] len_q, dig_q, ltr_q, nonltr_q;
	logic [7:0] prev_q;
	ppc_pkg::flags_t flags_q;
	logic [CODE_DEPTH-1:0] vld_q;

	// output register
	logic out_vld_q;
	ppc_pkg::status_t status_q;
	logic [ppc_pkg::MASK_W-1:0] mask_q;

	logic [CNT_W-1:0] ram_rdata;
	logic take, end_pc, s1_adv, s1_fire, ram_we;
	logic [CNT_W-1:0] cnt_old, cnt_new;
	logic [CNT_W-1:0] len_n, dig_n, ltr_n, nonltr_n;
	ppc_pkg::flags_t flags_n;
	ppc_pkg::status_t eval_status;
	logic [ppc_pkg::MASK_W-1:0] eval_mask;

	ppc_ram #(
		.WIDTH (CNT_W),
		.DEPTH (CODE_DEPTH)
	) u_counts (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_s1),
		.wdata (cnt_new),
		.re    (accept),
		.raddr (in_idx),
		.rdata (ram_rdata)
	);

	always_comb begin
		take = !empty_s1;
		end_pc = empty_s1 || last_s1;
		s1_adv = !valid_s1 || !end_pc || !out_vld_q || out_ready;
		s1_fire = valid_s1 && s1_adv;
		ram_we = s1_fire && take;

		if (fwd_s1) begin
			cnt_old = fwd_data_s1;
		end else if (vld_q[idx_s1]) begin
			cnt_old = ram_rdata;
		end else begin
			cnt_old = '0;
		end
		cnt_new = sat_inc(cnt_old);

		flags_n = flags_q;
		len_n = len_q;
		dig_n = dig_q;
		ltr_n = ltr_q;
		nonltr_n = nonltr_q;
		if (take) begin
			if (len_q != '0) begin
				if (char_s1 != prev_q) begin
					flags_n.all_same = 1'b0;
				end
				if (ppc_pkg::is_digit(prev_q) && ppc_pkg::is_digit(char_s1)) begin
					flags_n.adj_digit = 1'b1;
				end
				if (!(ppc_pkg::is_alnum(prev_q) && ppc_pkg::is_alnum(char_s1) &&
						({1'b0, char_s1} == {1'b0, prev_q} + 9'd1))) begin
					flags_n.ascending = 1'b0;
				end
			end
			if (ppc_pkg::is_space(char_s1)) begin
				flags_n.space = 1'b1;
			end
			if (ppc_pkg::is_upper(char_s1)) begin
				flags_n.upper = 1'b1;
			end
			if (ppc_pkg::is_lower(char_s1)) begin
				flags_n.lower = 1'b1;
			end
			if (CMP_W'(cnt_new) > CMP_W'(cfg.max_repeat)) begin
				flags_n.repeat_hit = 1'b1;
			end
			if (ppc_pkg::is_digit(char_s1)) begin
				dig_n = sat_inc(dig_q);
			end
			if (ppc_pkg::is_letter(char_s1)) begin
				ltr_n = sat_inc(ltr_q);
			end else begin
				nonltr_n = sat_inc(nonltr_q);
			end
			len_n = sat_inc(len_q);
		end
	end

	ppc_policy_eval #(
		.CNT_W (CNT_W)
	) u_eval (
		.cfg        (cfg),
		.len_cnt    (len_n),
		.dig_cnt    (dig_n),
		.ltr_cnt    (ltr_n),
		.nonltr_cnt (nonltr_n),
		.flags      (flags_n),
		.status     (eval_status),
		.mask       (eval_mask)
	);

	assign in_ready = s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			if (s1_adv) begin
				valid_s1 <= accept;
			end
			if (accept) begin
				// same code written back this edge: RAM read returns the old count
				fwd_s1 <= ram_we && !end_pc && (idx_s1 == in_idx);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= char_code;
			last_s1 <= is_last;
			empty_s1 <= is_empty;
			idx_s1 <= in_idx;
			fwd_data_s1 <= cnt_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			dig_q <= '0;
			ltr_q <= '0;
			nonltr_q <= '0;
			prev_q <= '0;
			flags_q <= ppc_pkg::FLAGS_CLEAR;
			vld_q <= '0;
		end else if (s1_fire) begin
			if (end_pc) begin
				len_q <= '0;
				dig_q <= '0;
				ltr_q <= '0;
				nonltr_q <= '0;
				prev_q <= '0;
				flags_q <= ppc_pkg::FLAGS_CLEAR;
				vld_q <= '0;
			end else if (take) begin
				len_q <= len_n;
				dig_q <= dig_n;
				ltr_q <= ltr_n;
				nonltr_q <= nonltr_n;
				prev_q <= char_s1;
				flags_q <= flags_n;
				vld_q[idx_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_fire && end_pc) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && end_pc) begin
			status_q <= eval_status;
			mask_q <= eval_mask;
		end
	end

	assign out_valid = out_vld_q;
	assign status = status_q;
	assign failed_mask = mask_q;

`ifndef SYNTH
	a_arg_err_no_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ppc_pkg::ST_ARG_ERR) |-> failed_mask == '0)
		else $error("argument error word carries a failed mask");

	a_status_matches_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ppc_pkg::ST_ARG_ERR) |->
			((status == ppc_pkg::ST_VIOLATION) == (failed_mask != '0)))
		else $error("status disagrees with failed mask");

	a_stall_only_on_full_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_adv |-> end_pc && out_vld_q && !out_ready)
		else $error("stage 1 stalled without a blocked result");

	a_state_cleared_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && end_pc |=> (len_q == '0) && (vld_q == '0) && (flags_q == ppc_pkg::FLAGS_CLEAR))
		else $error("passcode state not cleared after ending word");

	a_fwd_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && fwd_s1 |-> vld_q[idx_s1])
		else $error("count forwarded for a code with no live count");
`endif

endmodule

// ----- sim/tb_passcode_policy_checker_top.sv -----
// Self-checking testbench for passcode_policy_checker_top: random handshakes, in-bench policy predictor.
`timescale 1ns / 1ps

module tb_passcode_policy_checker_top;
	import ppc_pkg::*;

	localparam logic [LEN_W-1:0] SAT_LEN = LEN_W'(DEF_MAX_PASSCODE + 1);

	typedef struct {
		logic [7:0] code;
		logic       last;
		logic       empty;
	} word_t;

	typedef struct {
		status_t           status;
		logic [MASK_W-1:0] mask;
	} verdict_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [7:0]            char_code = 8'h00;
	logic                  is_last = 1'b0;
	logic                  is_empty = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [1:0]            status;
	logic [MASK_W-1:0]     failed_mask;

	word_t    pending_words[$];
	verdict_t due_verdicts[$];
	word_t    send_w;
	verdict_t exp_v;
	int       words_queued = 0;
	int       words_taken = 0;
	int       mismatches = 0;
	int       burst_left = 0;
	int       gap_left = 0;
	int       stall_left = 0;
	bit       steady_send = 1'b0;
	bit       steady_recv = 1'b0;
	logic [7:0] scratch[$];

	// predictor state
	cfg_t       policy;
	logic [8:0] code_tally[256];
	logic [8:0] len_cnt, dig_cnt, let_cnt, nonlet_cnt;
	logic [7:0] last_char;
	flags_t     seen;

	passcode_policy_checker_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.char_code(char_code),
		.is_last(is_last),
		.is_empty(is_empty),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.failed_mask(failed_mask)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit ch_num(input logic [7:0] c);
		return c >= 8'd48 && c <= 8'd57;
	endfunction

	function automatic bit ch_cap(input logic [7:0] c);
		return c >= 8'd65 && c <= 8'd90;
	endfunction

	function automatic bit ch_small(input logic [7:0] c);
		return c >= 8'd97 && c <= 8'd122;
	endfunction

	function automatic bit ch_alpha(input logic [7:0] c);
		return ch_cap(c) || ch_small(c);
	endfunction

	function automatic bit ch_word(input logic [7:0] c);
		return ch_alpha(c) || ch_num(c);
	endfunction

	function automatic bit ch_blank(input logic [7:0] c);
		return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic [8:0] bump(input logic [8:0] v);
		return (v < SAT_LEN) ? v + 9'd1 : v;
	endfunction

	function automatic void clear_tallies();
		foreach (code_tally[i])
			code_tally[i] = '0;
		len_cnt = '0;
		dig_cnt = '0;
		let_cnt = '0;
		nonlet_cnt = '0;
		last_char = '0;
		seen = FLAGS_CLEAR;
	endfunction

	function automatic void tally_char(input logic [7:0] c);
		if (len_cnt != 0) begin
			if (c != last_char)
				seen.all_same = 1'b0;
			if (ch_num(last_char) && ch_num(c))
				seen.adj_digit = 1'b1;
			if (!(ch_word(last_char) && ch_word(c) && {1'b0, c} == {1'b0, last_char} + 9'd1))
				seen.ascending = 1'b0;
		end
		if (ch_blank(c))
			seen.space = 1'b1;
		if (ch_cap(c))
			seen.upper = 1'b1;
		if (ch_small(c))
			seen.lower = 1'b1;
		if (ch_num(c))
			dig_cnt = bump(dig_cnt);
		if (ch_alpha(c))
			let_cnt = bump(let_cnt);
		else
			nonlet_cnt = bump(nonlet_cnt);
		code_tally[c] = bump(code_tally[c]);
		if (code_tally[c] > policy.max_repeat)
			seen.repeat_hit = 1'b1;
		len_cnt = bump(len_cnt);
		last_char = c;
	endfunction

	function automatic verdict_t grade_passcode();
		verdict_t v;
		v.mask = '0;
		if (seen.space) begin
			v.status = ST_ARG_ERR;
		end else begin
			if (policy.min_length != 0) begin
				if (len_cnt < policy.min_length)
					v.mask[MB_SHORT] = 1'b1;
				else if (len_cnt > policy.max_length)
					v.mask[MB_LONG] = 1'b1;
			end
			if (policy.max_repeat != 0 && seen.repeat_hit)
				v.mask[MB_REPEAT] = 1'b1;
			if (policy.need_letters_digits && (dig_cnt >= len_cnt || let_cnt >= len_cnt ||
					dig_cnt == 0 || let_cnt == 0))
				v.mask[MB_LETTERS_DIGITS] = 1'b1;
			if (policy.forbid_adjacent_digits && seen.adj_digit)
				v.mask[MB_ADJ_DIGITS] = 1'b1;
			if (policy.need_upper_lower && !(seen.upper && seen.lower))
				v.mask[MB_CASE] = 1'b1;
			if (policy.min_nonletters != 0 && nonlet_cnt < policy.min_nonletters)
				v.mask[MB_NONLETTERS] = 1'b1;
			if (policy.forbid_simple) begin
				if (seen.all_same)
					v.mask[MB_ALL_SAME] = 1'b1;
				if (seen.ascending)
					v.mask[MB_ASCENDING] = 1'b1;
			end
			v.status = (v.mask != 0) ? ST_VIOLATION : ST_ACCEPT;
		end
		return v;
	endfunction

	function automatic void score_word(input logic [7:0] c, input logic last, input logic empty);
		if (!empty)
			tally_char(c);
		if (empty || last) begin
			due_verdicts.push_back(grade_passcode());
			clear_tallies();
		end
	endfunction

	// sender: bursts with random gaps, valid held until accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			char_code <= 8'h00;
			is_last <= 1'b0;
			is_empty <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (in_valid && in_ready) begin
				score_word(char_code, is_last, is_empty);
				words_taken++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_words.size() != 0) begin
					send_w = pending_words.pop_front();
					in_valid <= 1'b1;
					char_code <= send_w.code;
					is_last <= send_w.last;
					is_empty <= send_w.empty;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 24);
						if (steady_send)
							gap_left = 0;
						else if ($urandom_range(0, 3) == 0)
							gap_left = $urandom_range(4, 15);
						else
							gap_left = $urandom_range(0, 2);
					end else begin
						burst_left--;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stall runs, checks each result against the oldest verdict
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_verdicts.size() == 0) begin
					$error("unexpected result: status %0d, failed_mask %h", status, failed_mask);
					mismatches++;
				end else begin
					exp_v = due_verdicts.pop_front();
					if (status !== exp_v.status) begin
						$error("status: expected %0d, got %0d", exp_v.status, status);
						mismatches++;
					end
					if (failed_mask !== exp_v.mask) begin
						$error("failed_mask: expected %h, got %h", exp_v.mask, failed_mask);
						mismatches++;
					end
				end
			end
			if (stall_left != 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!steady_recv && $urandom_range(0, 5) == 0)
					stall_left = $urandom_range(1, 12);
			end
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [8:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MIN_LENGTH: policy.min_length = val;
			REG_MAX_LENGTH: policy.max_length = val;
			REG_MAX_REPEAT: policy.max_repeat = val;
			REG_NEED_LETTERS_DIGITS: policy.need_letters_digits = val[0];
			REG_NEED_UPPER_LOWER: policy.need_upper_lower = val[0];
			REG_FORBID_ADJ_DIGITS: policy.forbid_adjacent_digits = val[0];
			REG_MIN_NONLETTERS: policy.min_nonletters = val;
			REG_FORBID_SIMPLE: policy.forbid_simple = val[0];
			default: ;
		endcase
	endtask

	task automatic apply_policy(input logic [8:0] min_len, input logic [8:0] max_len,
			input logic [8:0] rep, input logic [8:0] ld, input logic [8:0] ul,
			input logic [8:0] adj, input logic [8:0] nonlet, input logic [8:0] simple);
		write_reg(REG_MIN_LENGTH, min_len);
		write_reg(REG_MAX_LENGTH, max_len);
		write_reg(REG_MAX_REPEAT, rep);
		write_reg(REG_NEED_LETTERS_DIGITS, ld);
		write_reg(REG_NEED_UPPER_LOWER, ul);
		write_reg(REG_FORBID_ADJ_DIGITS, adj);
		write_reg(REG_MIN_NONLETTERS, nonlet);
		write_reg(REG_FORBID_SIMPLE, simple);
	endtask

	function automatic logic [8:0] pick_len(input int lo, input int hi);
		case ($urandom_range(0, 9))
			0: return 9'd0;
			1: return 9'd255;
			2: return 9'd256;
			3: return 9'd511;
			default: return 9'($urandom_range(lo, hi));
		endcase
	endfunction

	function automatic logic [7:0] rand_char();
		logic [7:0] c;
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 30)
			c = 8'($urandom_range(97, 122));
		else if (sel < 50)
			c = 8'($urandom_range(65, 90));
		else if (sel < 75)
			c = 8'($urandom_range(48, 57));
		else if (sel < 85)
			c = 8'($urandom_range(33, 126));
		else if (sel < 92)
			c = 8'($urandom_range(128, 255));
		else begin
			c = 8'($urandom_range(0, 255));
			while (ch_blank(c))
				c = 8'($urandom_range(0, 255));
		end
		return c;
	endfunction

	task automatic queue_passcode(input logic [7:0] cs[$], input bit by_empty);
		word_t w;
		foreach (cs[i]) begin
			w.code = cs[i];
			w.last = !by_empty && (i == cs.size() - 1);
			w.empty = 1'b0;
			pending_words.push_back(w);
			words_queued++;
		end
		if (by_empty || cs.size() == 0) begin
			w.code = 8'($urandom_range(0, 255));
			w.last = 1'($urandom_range(0, 1));
			w.empty = 1'b1;
			pending_words.push_back(w);
			words_queued++;
		end
	endtask

	task automatic queue_text(input string s, input bit by_empty);
		logic [7:0] cs[$];
		for (int i = 0; i < s.len(); i++)
			cs.push_back(s[i]);
		queue_passcode(cs, by_empty);
	endtask

	task automatic queue_random_passcode();
		logic [7:0] cs[$];
		logic [7:0] c, alt;
		int n;
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 24) : $urandom_range(0, 10);
		case ($urandom_range(0, 9))
			0: begin
				c = rand_char();
				repeat (n) cs.push_back(c);
			end
			1: begin
				case ($urandom_range(0, 2))
					0: c = 8'($urandom_range(48, 57));
					1: c = 8'($urandom_range(65, 90));
					default: c = 8'($urandom_range(97, 122));
				endcase
				repeat (n) begin
					cs.push_back(c);
					c = c + 8'd1;
				end
			end
			2: begin
				c = rand_char();
				alt = rand_char();
				repeat (n) cs.push_back($urandom_range(0, 1) ? c : alt);
			end
			3: repeat (n) cs.push_back(8'($urandom_range(48, 57)));
			default: repeat (n) cs.push_back(rand_char());
		endcase
		if ($urandom_range(0, 11) == 0)
			cs.insert($urandom_range(0, cs.size()),
				($urandom_range(0, 5) == 5) ? 8'd32 : 8'($urandom_range(9, 13)));
		queue_passcode(cs, cs.size() == 0 || $urandom_range(0, 5) == 0);
	endtask

	task automatic drain();
		@(posedge clk);
		while (words_taken != words_queued || due_verdicts.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_MIN_LENGTH;
		cfg_data = '0;
		policy = '0;
		policy.max_length = MAX_LENGTH_RST;
		clear_tallies();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// register defaults: everything disabled
		steady_send = 1'b1;
		steady_recv = 1'b1;
		queue_text("Ab1!", 1'b0);
		queue_text(" ", 1'b0);
		queue_text("", 1'b1);
		scratch.delete();
		scratch.push_back(8'h00);
		scratch.push_back(8'hff);
		queue_passcode(scratch, 1'b0);
		drain();

		// every policy on
		steady_send = 1'b0;
		steady_recv = 1'b0;
		apply_policy(9'd4, 9'd8, 9'd1, 9'd1, 9'd1, 9'd1, 9'd2, 9'd1);
		queue_text("", 1'b1);
		queue_text("a", 1'b0);
		queue_text("aaaa", 1'b0);
		queue_text("abcd", 1'b0);
		queue_text("Zz9\t", 1'b0);
		queue_text("Ab3$", 1'b1);
		drain();

		// long passcodes: counts saturate past the maximum
		apply_policy(9'd1, 9'd256, 9'd256, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0);
		scratch.delete();
		repeat (260) scratch.push_back(8'h61);
		queue_passcode(scratch, 1'b0);
		scratch.delete();
		repeat (257) scratch.push_back(rand_char());
		queue_passcode(scratch, 1'b0);
		drain();

		for (int phase = 0; words_queued < 1750; phase++) begin
			if (phase == 0)
				apply_policy('0, '0, '0, '0, '0, '0, '0, '0);
			else if (phase == 1)
				apply_policy('1, '1, '1, '1, '1, '1, '1, '1);
			else
				apply_policy(pick_len(1, 14), pick_len(4, 24), pick_len(1, 4),
					9'($urandom), 9'($urandom), 9'($urandom), pick_len(1, 5), 9'($urandom));
			steady_send = ($urandom_range(0, 3) == 0);
			steady_recv = ($urandom_range(0, 3) == 0);
			for (int goal = words_queued + 150; words_queued < goal; )
				queue_random_passcode();
			drain();
		end

		if (mismatches == 0 && due_verdicts.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#8_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
